// ===== rtl/core/pfa_pkg.sv =====
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SCAN_SLOTS = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;
  localparam int IDX_W      = (SCAN_SLOTS > 1) ? $clog2(SCAN_SLOTS) : 1;

  localparam int OP_W        = 1;
  localparam int SLOT_W      = 3;
  localparam int AMT_W       = 16;
  localparam int POL_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 2;

  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MODE = 2'd1;

  typedef struct packed {
    logic load_we;  // write a partition from the input word
    logic start;    // latch request, clear scan state
    logic step;     // examine one partition
    logic commit;   // update chosen partition, load result register
  } pfa_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic scan_last;
  } pfa_status_t;

endpackage

// ===== rtl/core/pfa_in_if.sv =====
`timescale 1ns / 1ps

interface pfa_in_if;
  import pfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SLOT_W-1:0] slot_index;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, output opcode, output slot_index, output amount,
                  input ready);
  modport sink   (input valid, input opcode, input slot_index, input amount,
                  output ready);
endinterface

// ===== rtl/core/pfa_out_if.sv =====
`timescale 1ns / 1ps

interface pfa_out_if;
  import pfa_pkg::*;

  logic              valid;
  logic              ready;
  logic              granted;
  logic [SLOT_W-1:0] chosen_slot;
  logic [AMT_W-1:0]  space_left;
  logic [AMT_W-1:0]  original_size;

  modport source (output valid, output granted, output chosen_slot,
                  output space_left, output original_size, input ready);
  modport sink   (input valid, input granted, input chosen_slot,
                  input space_left, input original_size, output ready);
endinterface

// ===== rtl/core/pfa_cfg_if.sv =====
`timescale 1ns / 1ps

interface pfa_cfg_if;
  import pfa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/pfa_ctrl.sv =====
`timescale 1ns / 1ps

module pfa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pfa_pkg::pfa_status_t status,
  output pfa_pkg::pfa_cmd_t    cmd
);
  import pfa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.load_we = accept && !status.is_alloc;
    cmd.start   = accept && status.is_alloc;
    case (state_r)
      S_IDLE: begin
        if (cmd.start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        // result register must be free (or draining) before overwrite
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/pfa_dpath.sv =====
`timescale 1ns / 1ps

module pfa_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [pfa_pkg::OP_W-1:0]       in_opcode,
  input  logic [pfa_pkg::SLOT_W-1:0]     in_slot_index,
  input  logic [pfa_pkg::AMT_W-1:0]      in_amount,
  input  logic                           cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  pfa_pkg::pfa_cmd_t              cmd,
  output pfa_pkg::pfa_status_t           status,
  output logic                           out_granted,
  output logic [pfa_pkg::SLOT_W-1:0]     out_chosen_slot,
  output logic [pfa_pkg::AMT_W-1:0]      out_space_left,
  output logic [pfa_pkg::AMT_W-1:0]      out_original_size
);
  import pfa_pkg::*;

  // config
  logic [POL_W-1:0] fit_policy_r;
  logic             fixed_mode_r;

  // partition table
  logic [AMT_W-1:0] slot_size_r [SCAN_SLOTS];
  logic [AMT_W-1:0] slot_left_r [SCAN_SLOTS];
  logic             slot_used_r [SCAN_SLOTS];

  // scan state
  logic [AMT_W-1:0] amt_r;
  logic [IDX_W-1:0] cnt_r;
  logic             found_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [AMT_W-1:0] best_left_r;
  logic [AMT_W-1:0] best_size_r;

  // result register
  logic             res_granted_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [AMT_W-1:0] res_left_r;
  logic [AMT_W-1:0] res_size_r;

  logic [AMT_W-1:0] cur_left;
  logic             fits;
  logic             take;
  logic [AMT_W-1:0] new_left;
  logic             load_ok;
  logic [IDX_W-1:0] load_idx;

  assign status.is_alloc  = (in_opcode == OP_ALLOC);
  assign status.scan_last = (cnt_r == IDX_W'(SCAN_SLOTS - 1));

  assign load_ok  = ({1'b0, in_slot_index} < (SLOT_W + 1)'(SCAN_SLOTS));
  assign load_idx = in_slot_index[IDX_W-1:0];

  assign cur_left = slot_left_r[cnt_r];
  assign fits     = !slot_used_r[cnt_r] && (cur_left >= amt_r);

  // strict compares keep the lowest index on ties; first fit never replaces
  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        case (fit_policy_r)
          POL_BEST:  take = (cur_left < best_left_r);
          POL_WORST: take = (cur_left > best_left_r);
          default:   take = 1'b0;
        endcase
      end
    end
  end

  assign new_left = best_left_r - amt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= POL_FIRST;
      fixed_mode_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIT_POLICY) fit_policy_r <= cfg_data[POL_W-1:0];
      if (cfg_index == CFG_FIXED_MODE) fixed_mode_r <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SCAN_SLOTS; k++) begin
        slot_size_r[k] <= '0;
        slot_left_r[k] <= '0;
        slot_used_r[k] <= 1'b0;
      end
    end else if (cmd.load_we) begin
      if (load_ok) begin
        slot_size_r[load_idx] <= in_amount;
        slot_left_r[load_idx] <= in_amount;
        slot_used_r[load_idx] <= 1'b0;
      end
    end else if (cmd.commit && found_r) begin
      slot_left_r[best_idx_r] <= new_left;
      if (fixed_mode_r) slot_used_r[best_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.start) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
      if (take) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) amt_r <= in_amount;
    if (cmd.step && take) begin
      best_idx_r  <= cnt_r;
      best_left_r <= cur_left;
      best_size_r <= slot_size_r[cnt_r];
    end
    if (cmd.commit) begin
      res_granted_r <= found_r;
      res_slot_r    <= found_r ? SLOT_W'(best_idx_r) : '0;
      res_left_r    <= found_r ? new_left : '0;
      res_size_r    <= found_r ? best_size_r : '0;
    end
  end

  assign out_granted       = res_granted_r;
  assign out_chosen_slot   = res_slot_r;
  assign out_space_left    = res_left_r;
  assign out_original_size = res_size_r;

endmodule

// ===== rtl/core/partition_fit_allocator_unit.sv =====
`timescale 1ns / 1ps

// channel | dir | handshake     | word
// in_ch   | in  | valid / ready | opcode, slot_index, amount
// out_ch  | out | valid / ready | granted, chosen_slot, space_left, original_size
// cfg_ch  | in  | valid / ready | index (0 fit_policy, 1 fixed_mode), data
//
// A load word is written into the table in its accept cycle.
// For an allocate word the scan examines one partition per cycle, then S_DONE
// updates the chosen partition and loads the result register.
// Input is taken again while a result still waits; the update stalls on out_ch.
// Reset (rst_n low, synchronous) empties the table and sets first fit, fixed.
// cfg_ch is always ready.
module partition_fit_allocator_unit (
  input logic clk,
  input logic rst_n,
  pfa_in_if.sink    in_ch,
  pfa_out_if.source out_ch,
  pfa_cfg_if.sink   cfg_ch
);
  import pfa_pkg::*;

  pfa_cmd_t    cmd;
  pfa_status_t status;

  assign cfg_ch.ready = 1'b1;

  pfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pfa_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_opcode         (in_ch.opcode),
    .in_slot_index     (in_ch.slot_index),
    .in_amount         (in_ch.amount),
    .cfg_we            (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .cmd               (cmd),
    .status            (status),
    .out_granted       (out_ch.granted),
    .out_chosen_slot   (out_ch.chosen_slot),
    .out_space_left    (out_ch.space_left),
    .out_original_size (out_ch.original_size)
  );

endmodule

// ===== rtl/core/pfa_checker.sv =====
`timescale 1ns / 1ps

module pfa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_granted,
  input logic [pfa_pkg::SLOT_W-1:0] out_chosen_slot,
  input logic [pfa_pkg::AMT_W-1:0]  out_space_left,
  input logic [pfa_pkg::AMT_W-1:0]  out_original_size
);
  import pfa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_granted) && $stable(out_chosen_slot) &&
      $stable(out_space_left) && $stable(out_original_size))
    else $error("result word changed while stalled");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |->
      out_chosen_slot == '0 && out_space_left == '0 && out_original_size == '0)
    else $error("refused result carries nonzero fields");

  a_left_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> out_space_left <= out_original_size)
    else $error("space left exceeds partition size");

endmodule

bind partition_fit_allocator_unit pfa_checker u_pfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_granted       (out_ch.granted),
  .out_chosen_slot   (out_ch.chosen_slot),
  .out_space_left    (out_ch.space_left),
  .out_original_size (out_ch.original_size)
);
